// File: rtl/cpg_pkg.sv
package cpg_pkg;

    // CORDIC working format: angles in 2^-32 turn, magnitudes scaled by 2^30
    localparam int CordicSteps = 18;
    localparam int StepWidth   = 5;
    localparam int CordicWidth = 34;
    localparam int AngleWidth  = 32;
    localparam int PhaseWidth  = 16;
    localparam int TrigWidth   = 17;
    localparam int SegWidth    = 7;
    localparam int IndexWidth  = 6;

    localparam logic signed [CordicWidth-1:0] GainInv = 34'sd652032874;
    localparam logic [31:0] PiQ30 = 32'd3373259426;

    typedef logic signed [CordicWidth-1:0] cordic_t;
    typedef logic signed [AngleWidth-1:0]  angle_t;
    typedef logic signed [TrigWidth-1:0]   trig_t;

    // arctangent of 2^-k, in 2^-32 turn
    function automatic angle_t atan_lookup(input logic [StepWidth-1:0] k);
        angle_t a;
        case (k)
            5'd0:  a = 32'sd536870912;
            5'd1:  a = 32'sd316933406;
            5'd2:  a = 32'sd167458907;
            5'd3:  a = 32'sd85004756;
            5'd4:  a = 32'sd42667331;
            5'd5:  a = 32'sd21354465;
            5'd6:  a = 32'sd10679838;
            5'd7:  a = 32'sd5340245;
            5'd8:  a = 32'sd2670163;
            5'd9:  a = 32'sd1335087;
            5'd10: a = 32'sd667544;
            5'd11: a = 32'sd333772;
            5'd12: a = 32'sd166886;
            5'd13: a = 32'sd83443;
            5'd14: a = 32'sd41722;
            5'd15: a = 32'sd20861;
            5'd16: a = 32'sd10430;
            5'd17: a = 32'sd5215;
            default: a = '0;
        endcase
        return a;
    endfunction

    // round a 2^30 value to 2^15, ties up, clamp to +-32768
    function automatic trig_t to_q15(input cordic_t v);
        logic signed [CordicWidth:0] r;
        r = ($signed({v[CordicWidth-1], v}) + (35'sd1 <<< 14)) >>> 15;
        if (r > 35'sd32768)
            return 17'sd32768;
        if (r < -35'sd32768)
            return -17'sd32768;
        return r[TrigWidth-1:0];
    endfunction

endpackage

// File: rtl/cpg_if.sv
interface cpg_if #(parameter int PW = 8);
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cpg_cordic.sv
// Shared CORDIC rotator: one micro-rotation per cycle, quadrant fold at the end.
module cpg_cordic
    import cpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PhaseWidth-1:0] phase,
    output logic                  done,
    output trig_t                 cos_out,
    output trig_t                 sin_out
);

    cordic_t x_reg, y_reg;
    angle_t  z_reg;
    logic [1:0] quad_reg;
    logic [StepWidth-1:0] k_reg;
    logic busy_reg, done_reg;
    trig_t c_q, s_q;

    // one rotation step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= GainInv;
            y_reg    <= '0;
            z_reg    <= $signed({2'b00, phase[PhaseWidth-3:0], 16'd0});
            quad_reg <= phase[PhaseWidth-1:PhaseWidth-2];
        end
        else if (busy_reg)
        begin
            if (!z_reg[AngleWidth-1])
            begin
                x_reg <= x_reg - (y_reg >>> k_reg);
                y_reg <= y_reg + (x_reg >>> k_reg);
                z_reg <= z_reg - atan_lookup(k_reg);
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> k_reg);
                y_reg <= y_reg - (x_reg >>> k_reg);
                z_reg <= z_reg + atan_lookup(k_reg);
            end
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == StepWidth'(CordicSteps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quadrant fold
    always_comb
    begin
        c_q = to_q15(x_reg);
        s_q = to_q15(y_reg);
        case (quad_reg)
            2'd0:    begin cos_out = c_q;  sin_out = s_q;  end
            2'd1:    begin cos_out = -s_q; sin_out = c_q;  end
            2'd2:    begin cos_out = -c_q; sin_out = -s_q; end
            default: begin cos_out = s_q;  sin_out = -c_q; end
        endcase
    end

    assign done = done_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("cordic done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("cordic done while busy");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> k_reg < StepWidth'(CordicSteps)) else $error("step overrun");
`endif

endmodule

// File: rtl/cpg_divider.sv
// Restoring divider: (i << 16) / n, one quotient bit per cycle.
module cpg_divider
    import cpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [IndexWidth-1:0] index,
    input  logic [SegWidth-1:0]   divisor,
    output logic                  done,
    output logic [PhaseWidth-1:0] quotient
);

    localparam int NumWidth = IndexWidth + PhaseWidth;
    localparam int CntWidth = $clog2(NumWidth + 1);

    logic [NumWidth-1:0] num_reg;
    logic [SegWidth:0]   rem_reg;
    logic [CntWidth-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [SegWidth:0] trial;
    logic [SegWidth:0] diff;

    assign trial = {rem_reg[SegWidth-1:0], num_reg[NumWidth-1]};
    assign diff  = trial - {1'b0, divisor};

    // shift-subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {index, {PhaseWidth{1'b0}}};
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[SegWidth])
            begin
                rem_reg <= diff;
                num_reg <= {num_reg[NumWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[NumWidth-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(NumWidth - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg[PhaseWidth-1:0];

`ifndef SYNTHESIS
    a_div_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && divisor != '0 |-> rem_reg < {1'b0, divisor})
        else $error("remainder out of range");
`endif

endmodule

// File: rtl/circle_polygon_generator.sv
// Per request: an automatic-count step when the segment count is zero, then a clamp
// step; per vertex: the bit-serial phase divide, the CORDIC rotation and the X and Y
// multiply states. Requests are handled one at a time: a new one is taken only after
// the last vertex word has left, and each vertex waits for the word before it to be taken.
// Zero radius is accepted and dropped in the same cycle, with no words.
// Reset (rst_n, async low) returns the sequencer to idle and drops out_valid.
module circle_polygon_generator
    import cpg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_WIDTH  = 24
)
(
    input  logic clk,
    input  logic rst_n,
    cpg_if.sink   in_ch,
    cpg_if.source out_ch
);

    localparam int InWidth  = 3 * COORD_WIDTH - 1 + SegWidth;
    localparam int OutWidth = 2 * (COORD_WIDTH + 1) + IndexWidth + 1;
    localparam int ProdWidth = COORD_WIDTH + TrigWidth;
    localparam int AutoWidth = COORD_WIDTH + 32;

    // automatic count bounds on rad*PiQ30/2^38: below 15 gives under 3 segments,
    // 5*(MAX_SEGMENTS+1) and up gives more than MAX_SEGMENTS
    localparam logic [AutoWidth-1:0] AutoLow  = AutoWidth'(15);
    localparam logic [AutoWidth-1:0] AutoHigh = AutoWidth'(5 * (MAX_SEGMENTS + 1));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AUTO  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_TRIG  = 3'd3;
    localparam logic [2:0] S_MULX  = 3'd4;
    localparam logic [2:0] S_MULY  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_CLAMP = 3'd7;

    logic [2:0] state_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic [COORD_WIDTH-2:0] rad_reg;
    logic [SegWidth-1:0] n_reg;
    logic [IndexWidth-1:0] idx_reg;
    trig_t cos_reg, sin_reg;
    logic signed [COORD_WIDTH:0] px_reg, py_reg;
    logic out_valid_reg;
    logic [COORD_WIDTH+31:0] auto_reg;

    logic [COORD_WIDTH-2:0] in_rad;
    logic [SegWidth-1:0] in_seg;
    logic div_start, div_done, cor_start, cor_done;
    logic [IndexWidth-1:0] div_index;
    logic [PhaseWidth-1:0] quot;
    trig_t cos_w, sin_w;
    trig_t mul_t;
    logic signed [ProdWidth-1:0] prod;
    logic signed [ProdWidth-1:0] scaled;
    logic is_last;
    logic [AutoWidth-1:0] auto_sh;
    logic [17:0] auto_div;

    assign in_rad = in_ch.data[SegWidth +: COORD_WIDTH-1];
    assign in_seg = in_ch.data[SegWidth-1:0];

    // next vertex index is loaded into the divider as the current one leaves
    assign div_index = (state_reg == S_OUT) ? idx_reg + 1'b1 : idx_reg;

    cpg_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .index(div_index),
        .divisor(n_reg), .done(div_done), .quotient(quot)
    );

    cpg_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .phase(quot),
        .done(cor_done), .cos_out(cos_w), .sin_out(sin_w)
    );

    // shared radius multiplier with round-half-up
    assign mul_t  = (state_reg == S_MULX) ? cos_reg : sin_reg;
    assign prod   = $signed({1'b0, rad_reg}) * mul_t;
    assign scaled = (prod + (ProdWidth'(1) <<< 14)) >>> 15;
    assign is_last = ({1'b0, idx_reg} + 1'b1) == n_reg;

    // automatic count: divide by 2560*2^29 = 5 * 2^38, the /5 as *205 >> 10
    // (exact below 1024)
    assign auto_sh  = auto_reg >> 38;
    assign auto_div = {9'd0, auto_sh[8:0]} * 18'd205;

    assign div_start = (state_reg == S_CLAMP) || (state_reg == S_OUT && !out_valid_reg
                        && !is_last);
    assign cor_start = (state_reg == S_DIV) && div_done;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {px_reg, py_reg, idx_reg, is_last};

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_ch.valid && in_rad != '0)
                        state_reg <= (in_seg == '0) ? S_AUTO : S_CLAMP;
                end
                S_AUTO:  state_reg <= S_CLAMP;
                S_CLAMP: state_reg <= S_DIV;
                S_DIV:   if (div_done) state_reg <= S_TRIG;
                S_TRIG:  if (cor_done) state_reg <= S_MULX;
                S_MULX:  state_reg <= S_MULY;
                S_MULY:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_valid_reg && out_ch.ready)
                        out_valid_reg <= 1'b0;
                    else if (!out_valid_reg)
                    begin
                        if (is_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // request and vertex datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cx_reg  <= in_ch.data[InWidth-1 -: COORD_WIDTH];
                cy_reg  <= in_ch.data[InWidth-1-COORD_WIDTH -: COORD_WIDTH];
                rad_reg <= in_rad;
                n_reg   <= in_seg;
            end
            S_AUTO:
            begin
                auto_reg <= (COORD_WIDTH+32)'(rad_reg) * PiQ30;
            end
            S_CLAMP:
            begin
                if (n_reg == '0)
                begin
                    if (auto_sh < AutoLow)
                        n_reg <= SegWidth'(3);
                    else if (auto_sh >= AutoHigh)
                        n_reg <= SegWidth'(MAX_SEGMENTS);
                    else
                        n_reg <= auto_div[16:10];
                end
                else if (n_reg > SegWidth'(MAX_SEGMENTS))
                    n_reg <= SegWidth'(MAX_SEGMENTS);
            end
            S_TRIG:
            begin
                if (cor_done)
                begin
                    cos_reg <= cos_w;
                    sin_reg <= sin_w;
                end
            end
            S_MULX:
            begin
                px_reg <= $signed({cx_reg[COORD_WIDTH-1], cx_reg})
                          + scaled[COORD_WIDTH:0];
            end
            S_MULY:
            begin
                py_reg <= $signed({cy_reg[COORD_WIDTH-1], cy_reg})
                          + scaled[COORD_WIDTH:0];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT) else $error("valid outside output");
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> n_reg != '0 && n_reg <= SegWidth'(MAX_SEGMENTS))
        else $error("segment count out of range");
`endif

endmodule

// File: bench/circle_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the vertex stream of each accepted request and
// compares every output word with the oldest predicted vertex.
module circle_checker
    import cpg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_WIDTH  = 24
)
(
    input  logic clk,
    input  logic rst_n,
    cpg_if       in_ch,
    cpg_if       out_ch,
    output int   errors,
    output int   pending,
    output int   vertices_seen,
    output int   requests_seen
);

    typedef struct {
        logic signed [COORD_WIDTH:0] px;
        logic signed [COORD_WIDTH:0] py;
        logic [IndexWidth-1:0]       idx;
        logic                        last;
    } vertex_t;

    vertex_t vertex_q[$];

    // floor shift of a signed 64-bit value
    function automatic longint asr(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic longint round_q15(input longint v);
        longint r;
        r = asr(v + (64'sd1 <<< 14), 15);
        if (r > 32768)
            r = 32768;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint atan_turn(input int k);
        longint tbl[18];
        tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215};
        return tbl[k];
    endfunction

    // sine and cosine of a 16-bit turn fraction, scaled by 2^15
    task automatic rotate(input logic [15:0] phase, output longint sn, output longint cs);
        longint x, y, z, dx, dy, c, s;
        logic [1:0] quad;
        quad = phase[15:14];
        z = longint'(phase[13:0]) <<< 16;
        x = 652032874;
        y = 0;
        for (int k = 0; k < 18; k++)
        begin
            dx = asr(y, k);
            dy = asr(x, k);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn(k);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn(k);
            end
        end
        c = round_q15(x);
        s = round_q15(y);
        case (quad)
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endtask

    // append the vertices one request produces
    task automatic predict_circle(input logic [3*COORD_WIDTH+SegWidth-2:0] word);
        longint cx, cy, rad, sn, cs, px, py;
        longint unsigned n;
        logic [15:0] phase;
        vertex_t v;
        cx  = longint'($signed(word[3*COORD_WIDTH+SegWidth-2 -: COORD_WIDTH]));
        cy  = longint'($signed(word[2*COORD_WIDTH+SegWidth-2 -: COORD_WIDTH]));
        rad = longint'(word[COORD_WIDTH+SegWidth-2 -: COORD_WIDTH-1]);
        n   = longint'(word[SegWidth-1:0]);
        if (rad == 0)
            return;
        if (n == 0)
        begin
            n = (longint'(rad) * 64'd3373259426) / (64'd2560 << 29);
            if (n < 3)
                n = 3;
        end
        if (n > MAX_SEGMENTS)
            n = MAX_SEGMENTS;
        for (longint unsigned i = 0; i < n; i++)
        begin
            phase = 16'(((i << 16) / n) & 64'hFFFF);
            rotate(phase, sn, cs);
            px = cx + asr(rad * cs + (64'sd1 <<< 14), 15);
            py = cy + asr(rad * sn + (64'sd1 <<< 14), 15);
            v.px = px[COORD_WIDTH:0];
            v.py = py[COORD_WIDTH:0];
            v.idx = i[IndexWidth-1:0];
            v.last = (i + 1 == n);
            vertex_q = {vertex_q, v};
        end
    endtask

    // sample both channels at each edge
    always @(posedge clk)
    begin
        vertex_t exp_v;
        logic signed [COORD_WIDTH:0] got_x, got_y;
        logic [IndexWidth-1:0] got_idx;
        logic got_last;
        if (!rst_n)
        begin
            errors = 0;
            vertices_seen = 0;
            requests_seen = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_circle(in_ch.data);
                requests_seen++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                vertices_seen++;
                {got_x, got_y, got_idx, got_last} = out_ch.data;
                if (vertex_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected vertex word x=%0d y=%0d idx=%0d last=%0b",
                             $time, got_x, got_y, got_idx, got_last);
                end
                else
                begin
                    exp_v = vertex_q.pop_front();
                    if (got_x !== exp_v.px)
                    begin
                        errors++;
                        $display("%0t: point_x expected %0d actual %0d", $time, exp_v.px, got_x);
                    end
                    if (got_y !== exp_v.py)
                    begin
                        errors++;
                        $display("%0t: point_y expected %0d actual %0d", $time, exp_v.py, got_y);
                    end
                    if (got_idx !== exp_v.idx)
                    begin
                        errors++;
                        $display("%0t: point_index expected %0d actual %0d",
                                 $time, exp_v.idx, got_idx);
                    end
                    if (got_last !== exp_v.last)
                    begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b", $time, exp_v.last, got_last);
                    end
                end
            end
        end
        pending = vertex_q.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpg_pkg::*;

    localparam int CW      = 24;
    localparam int IN_W    = 3 * CW + SegWidth - 1;
    localparam int OUT_W   = 2 * (CW + 1) + IndexWidth + 1;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors, pending, vertices_seen, requests_seen;
    int   idle_cycles;
    logic long_hold;
    logic hold_done;

    cpg_if #(.PW(IN_W))  in_ch ();
    cpg_if #(.PW(OUT_W)) out_ch ();

    circle_polygon_generator #(.MAX_SEGMENTS(64), .COORD_WIDTH(CW)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    circle_checker #(.MAX_SEGMENTS(64), .COORD_WIDTH(CW)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .errors        (errors),
        .pending       (pending),
        .vertices_seen (vertices_seen),
        .requests_seen (requests_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // no gap or a short one most of the time, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // offer one request word and wait until it is taken
    task automatic send_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                               input logic [CW-2:0] rad, input logic [SegWidth-1:0] seg,
                               input bit use_gap);
        int gap;
        in_ch.data  <= {cx, cy, rad, seg};
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        gap = use_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random request, skewed toward small vertex counts
    task automatic send_random(input bit use_gap);
        logic [CW-1:0] cx, cy;
        logic [CW-2:0] rad;
        logic [SegWidth-1:0] seg;
        int sel;
        cx = CW'($urandom);
        cy = CW'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50)
            rad = (CW-1)'($urandom_range(1, 30000));
        else if (sel < 90)
            rad = (CW-1)'($urandom);
        else if (sel < 95)
            rad = (CW-1)'($urandom_range(0, 3));
        else
            rad = '0;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            seg = SegWidth'($urandom_range(1, 8));
        else if (sel < 75)
            seg = SegWidth'($urandom_range(9, 24));
        else if (sel < 80)
            seg = SegWidth'($urandom_range(25, 127));
        else
        begin
            seg = '0;
            if ($urandom_range(0, 9) != 0)
                rad = (CW-1)'($urandom_range(1, 6000));
        end
        send_circle(cx, cy, rad, seg, use_gap);
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int span;
        out_ch.ready <= 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_done = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                     : $urandom_range(1, 4);
                repeat (span) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400)
                                                    : $urandom_range(1, 10);
                repeat (span) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [CW-1:0] max_pos, max_neg;
        max_pos = {1'b0, {(CW-1){1'b1}}};
        max_neg = {1'b1, {(CW-1){1'b0}}};
        long_hold = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero radius, field extremes, small and clamped counts, auto count
        send_circle('0, '0, '0, 7'd5, 1'b0);
        send_circle(max_pos, max_neg, '0, 7'd0, 1'b0);
        send_circle('0, '0, 23'd256, 7'd1, 1'b0);
        send_circle(24'd1000, -24'sd1000, 23'd512, 7'd2, 1'b0);
        send_circle('0, '0, 23'd2560, 7'd3, 1'b0);
        send_circle(max_pos, max_pos, {(CW-1){1'b1}}, 7'd4, 1'b1);
        send_circle(max_neg, max_neg, {(CW-1){1'b1}}, 7'd4, 1'b1);
        send_circle(max_pos, max_neg, {(CW-1){1'b1}}, 7'd64, 1'b1);
        send_circle(max_neg, max_pos, {(CW-1){1'b1}}, 7'd127, 1'b0);
        send_circle('0, '0, 23'd100, 7'd65, 1'b0);
        send_circle('0, '0, 23'd1, 7'd0, 1'b0);
        send_circle('0, '0, 23'd1222, 7'd0, 1'b0);
        send_circle('0, '0, 23'd1223, 7'd0, 1'b0);
        send_circle(24'd5, 24'd7, 23'd3000, 7'd0, 1'b1);
        send_circle('0, '0, 23'd26000, 7'd0, 1'b0);
        send_circle('0, '0, 23'd8000000, 7'd0, 1'b0);
        send_circle(24'h555555, 24'hAAAAAA, 23'h2AAAAA, 7'd6, 1'b1);
        send_circle(24'hAAAAAA, 24'h555555, 23'h555555, 7'd12, 1'b1);
        send_circle('0, '0, 23'd1, 7'd8, 1'b0);
        send_circle('1, '1, 23'd3, 7'd16, 1'b0);

        // pause until every vertex is out
        drain();

        // long receiver hold while requests keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++)
            send_random(1'b0);
        drain();

        for (int i = 0; i < 430; i++)
        begin
            if (i % 100 == 99)
                drain();
            send_random(i % 50 >= 10);
        end

        drain();
        in_ch.valid <= 1'b0;
        repeat (300) @(posedge clk);

        $display("Run covered %0d requests and %0d vertices, incl. zero radius, auto and",
                 requests_seen, vertices_seen);
        $display("clamped counts, extreme centres and radii, and a long output stall.");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cpg_pkg.sv
rtl/cpg_if.sv
rtl/cpg_cordic.sv
rtl/cpg_divider.sv
rtl/circle_polygon_generator.sv
bench/circle_checker.sv
bench/testbench.sv
